[rtl/rhps_pkg.sv]
// Ring halo pixel shader: shared beat types, register codes and constants.
// No dependencies.
package rhps_pkg;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [15:0] radius;
		logic [7:0]  ring_red;
		logic [7:0]  ring_green;
		logic [7:0]  ring_blue;
		logic [8:0]  glow;
		logic [7:0]  old_red;
		logic [7:0]  old_green;
		logic [7:0]  old_blue;
	} rhps_item_t;

	typedef struct packed {
		logic [7:0] new_red;
		logic [7:0] new_green;
		logic [7:0] new_blue;
		logic       touched;
	} rhps_result_t;

	localparam int COORD_INT_BITS_DEF  = 12;
	localparam int COORD_FRAC_BITS_DEF = 4;

	localparam int ADDR_W = 3;
	localparam logic REG_LINE = 1'b0;
	localparam logic REG_HALO = 1'b1;

	localparam logic [15:0] LINE_INV_RST = 16'd25206;
	localparam logic [15:0] HALO_INV_RST = 16'd8192;

	localparam logic [15:0] HALO_WEIGHT = 16'd24904;
	localparam logic [17:0] LINE_WEIGHT = 18'd144179;

	// start-to-done cycles for a given coordinate width
	function automatic int rhps_latency(int cb);
		return 12 + (cb + 10) / 2;
	endfunction

endpackage

[rtl/ring_halo_pixel_shader_top.sv]
// Ring halo pixel shader top level: distance, falloff, weighting and blend pipeline.
// Depends on rhps_pkg and rhps_sqrt.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------
//  item     | start / busy (=0)      | rhps_item_t item
//  result   | done strobe, 1 cycle   | rhps_result_t result
//  config   | APB psel/penable/...   | paddr, pwdata, prdata
//
// One beat per clock. The latency depends on CB, the coordinate width, through
// the square root pipeline.
// busy is never asserted; there is no stall on either side.
// Reset clears valid bits and restores both config registers, line_inv_q and halo_inv_q.
module ring_halo_pixel_shader_top #(
	parameter int COORD_INT_BITS  = rhps_pkg::COORD_INT_BITS_DEF,
	parameter int COORD_FRAC_BITS = rhps_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  rhps_pkg::rhps_item_t       item,
	output logic                       done,
	output rhps_pkg::rhps_result_t     result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rhps_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import rhps_pkg::*;

	localparam int CB    = COORD_INT_BITS + COORD_FRAC_BITS;
	localparam int N     = CB + 9;
	localparam int SHIFT = COORD_FRAC_BITS + 8;
	localparam int TW    = N + 16 - SHIFT;

	typedef struct packed {
		logic          skip;
		logic [CB-1:0] rad;
		logic [8:0]    glow;
		logic [7:0]    ring_red;
		logic [7:0]    ring_green;
		logic [7:0]    ring_blue;
		logic [7:0]    old_red;
		logic [7:0]    old_green;
		logic [7:0]    old_blue;
	} side_t;

	// config registers
	logic [15:0] line_inv_q;
	logic [15:0] halo_inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_inv_q <= LINE_INV_RST;
			halo_inv_q <= HALO_INV_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[ADDR_W-1])
				REG_LINE: line_inv_q <= pwdata[15:0];
				REG_HALO: halo_inv_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign prdata = {16'd0, (paddr[ADDR_W-1] == REG_HALO) ? halo_inv_q : line_inv_q};
	assign pready = 1'b1;
	assign busy   = 1'b0;

	// s1: pixel centre offsets
	logic [COORD_INT_BITS-1:0] px, py;
	logic [CB-1:0] pcx, pcy, cx, cy, rad_m;
	side_t side_in;

	assign px  = COORD_INT_BITS'(item.pixel_x);
	assign py  = COORD_INT_BITS'(item.pixel_y);
	assign pcx = {px, 1'b1, {(COORD_FRAC_BITS-1){1'b0}}};
	assign pcy = {py, 1'b1, {(COORD_FRAC_BITS-1){1'b0}}};
	assign cx  = CB'(item.center_x);
	assign cy  = CB'(item.center_y);
	assign rad_m = CB'(item.radius);

	always_comb begin
		side_in.skip       = (rad_m[CB-1:COORD_FRAC_BITS] == '0);
		side_in.rad        = rad_m;
		side_in.glow       = item.glow;
		side_in.ring_red   = item.ring_red;
		side_in.ring_green = item.ring_green;
		side_in.ring_blue  = item.ring_blue;
		side_in.old_red    = item.old_red;
		side_in.old_green  = item.old_green;
		side_in.old_blue   = item.old_blue;
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic root_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= root_vld;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	logic [CB-1:0]   adx_s1, ady_s1;
	side_t           side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	side_t           side_s7, side_s8, side_s9, side_s10, side_s11;
	logic [2*CB-1:0] sqx_s2, sqy_s2;
	logic [2*N-1:0]  v_s3;
	logic [N-1:0]    root;
	side_t           root_side;
	logic [N-1:0]    d_s4;
	logic [N+15:0]   ph_s5, pl_s5;
	logic [16:0]     hal_s6, cov_s6;
	logic [16:0]     hsq_s7, csq_s7;
	logic [32:0]     hw_s8;
	logic [34:0]     lw_s8;
	logic [34:0]     amt_s9;
	logic [43:0]     ag_s10;
	logic [7:0]      v_s11;

	// s6 falloff terms
	logic [TW-1:0]   th, tl;
	logic [16:0]     hal_n, cov_n;
	side_t           side_n6;
	// s7 squares
	logic [33:0]     hh, cc;
	// s11 scale by 255
	logic [51:0]     p255;
	// s12 blend
	logic [15:0]     mr, mg, mb;
	logic [8:0]      sr, sg, sb;

	always_ff @(posedge clk) begin
		adx_s1  <= (pcx >= cx) ? pcx - cx : cx - pcx;
		ady_s1  <= (pcy >= cy) ? pcy - cy : cy - pcy;
		side_s1 <= side_in;

		sqx_s2  <= adx_s1 * adx_s1;
		sqy_s2  <= ady_s1 * ady_s1;
		side_s2 <= side_s1;

		v_s3    <= {1'b0, ({1'b0, sqx_s2} + {1'b0, sqy_s2}), 16'd0};
		side_s3 <= side_s2;
	end

	rhps_sqrt #(
		.N      (N),
		.SIDE_W ($bits(side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (vld_s3),
		.square    (v_s3),
		.side_band (side_s3),
		.res_valid (root_vld),
		.root      (root),
		.res_side  (root_side)
	);

	logic [N-1:0] rq;
	assign rq = N'({root_side.rad, 8'd0});

	assign th = ph_s5[N+15:SHIFT];
	assign tl = pl_s5[N+15:SHIFT];
	assign hal_n = (th[TW-1:16] == '0) ? 17'h10000 - {1'b0, th[15:0]} : 17'd0;
	assign cov_n = (tl[TW-1:16] == '0) ? 17'h10000 - {1'b0, tl[15:0]} : 17'd0;

	always_comb begin
		side_n6      = side_s5;
		side_n6.skip = side_s5.skip || (hal_n == '0);
	end

	assign hh   = hal_s6 * hal_s6;
	assign cc   = cov_s6 * cov_s6;
	assign p255 = {ag_s10, 8'd0} - {8'd0, ag_s10};

	always_ff @(posedge clk) begin
		d_s4    <= (root >= rq) ? root - rq : rq - root;
		side_s4 <= root_side;

		ph_s5   <= d_s4 * halo_inv_q;
		pl_s5   <= d_s4 * line_inv_q;
		side_s5 <= side_s4;

		hal_s6  <= hal_n;
		cov_s6  <= cov_n;
		side_s6 <= side_n6;

		hsq_s7  <= hh[32:16];
		csq_s7  <= cc[32:16];
		side_s7 <= side_s6;

		hw_s8   <= hsq_s7 * HALO_WEIGHT;
		lw_s8   <= csq_s7 * LINE_WEIGHT;
		side_s8 <= side_s7;

		amt_s9  <= {2'b0, hw_s8} + lw_s8;
		side_s9 <= side_s8;

		ag_s10   <= amt_s9 * side_s9.glow;
		side_s10 <= side_s9;

		v_s11    <= (p255[51:48] != '0) ? 8'hFF : p255[47:40];
		side_s11 <= side_s10;
	end

	assign mr = side_s11.ring_red * v_s11;
	assign mg = side_s11.ring_green * v_s11;
	assign mb = side_s11.ring_blue * v_s11;
	assign sr = {1'b0, side_s11.old_red} + {1'b0, mr[15:8]};
	assign sg = {1'b0, side_s11.old_green} + {1'b0, mg[15:8]};
	assign sb = {1'b0, side_s11.old_blue} + {1'b0, mb[15:8]};

	rhps_result_t res_s12;

	always_ff @(posedge clk) begin
		if (side_s11.skip) begin
			res_s12.new_red   <= side_s11.old_red;
			res_s12.new_green <= side_s11.old_green;
			res_s12.new_blue  <= side_s11.old_blue;
			res_s12.touched   <= 1'b0;
		end else begin
			res_s12.new_red   <= sr[8] ? 8'hFF : sr[7:0];
			res_s12.new_green <= sg[8] ? 8'hFF : sg[7:0];
			res_s12.new_blue  <= sb[8] ? 8'hFF : sb[7:0];
			res_s12.touched   <= 1'b1;
		end
	end

	assign done   = vld_s12;
	assign result = res_s12;

endmodule

[rtl/rhps_sqrt.sv]
// Pipelined digit-by-digit integer square root, two root bits per stage,
// with a side band that travels alongside. No package dependency.
module rhps_sqrt #(
	parameter int N      = 25,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic [2*N-1:0]    square,
	input  logic [SIDE_W-1:0] side_band,
	output logic              res_valid,
	output logic [N-1:0]      root,
	output logic [SIDE_W-1:0] res_side
);
	localparam int STAGES = (N + 1) / 2;

	logic              vld_s  [STAGES+1];
	logic [2*N-1:0]    sq_s   [STAGES+1];
	logic [N+1:0]      rem_s  [STAGES+1];
	logic [N-1:0]      root_s [STAGES+1];
	logic [SIDE_W-1:0] side_s [STAGES+1];

	assign vld_s[0]  = valid;
	assign sq_s[0]   = square;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_band;

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		logic [2*N-1:0] sq_n;
		logic [N+1:0]   rem_n;
		logic [N-1:0]   root_n;

		always_comb begin
			logic [N+1:0] acc;
			logic [N+1:0] trial;
			sq_n   = sq_s[j];
			rem_n  = rem_s[j];
			root_n = root_s[j];
			for (int t = 0; t < 2; t++) begin
				if (2 * j + t < N) begin
					acc   = {rem_n[N-1:0], sq_n[2*N-1 -: 2]};
					trial = {root_n, 2'b01};
					sq_n  = sq_n << 2;
					if (acc >= trial) begin
						rem_n  = acc - trial;
						root_n = {root_n[N-2:0], 1'b1};
					end else begin
						rem_n  = acc;
						root_n = {root_n[N-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sq_s[j+1]   <= sq_n;
			rem_s[j+1]  <= rem_n;
			root_s[j+1] <= root_n;
			side_s[j+1] <= side_s[j];
		end
	end

	assign res_valid = vld_s[STAGES];
	assign root      = root_s[STAGES];
	assign res_side  = side_s[STAGES];

endmodule

[rtl/rhps_checker.sv]
// Port-level checks for the ring halo pixel shader, bound to the top level.
// Depends on rhps_pkg.
module rhps_checker #(
	parameter int COORD_INT_BITS  = rhps_pkg::COORD_INT_BITS_DEF,
	parameter int COORD_FRAC_BITS = rhps_pkg::COORD_FRAC_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input rhps_pkg::rhps_item_t   item,
	input logic                   done,
	input rhps_pkg::rhps_result_t result
);
	import rhps_pkg::*;

	localparam int LAT = rhps_latency(COORD_INT_BITS + COORD_FRAC_BITS);
	localparam int CW  = $clog2(LAT + 1);

	logic [CW-1:0] warm_q;
	logic          warm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != CW'(LAT)) begin
			warm_q <= warm_q + 1'b1;
		end
	end

	assign warm = (warm_q == CW'(LAT));

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy asserted");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LAT)))
		else $error("done does not follow start by the pipeline latency");

	a_untouched_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		warm && done && !result.touched |->
			result.new_red == $past(item.old_red, LAT) &&
			result.new_green == $past(item.old_green, LAT) &&
			result.new_blue == $past(item.old_blue, LAT))
		else $error("untouched pixel changed");

	a_never_darker: assert property (@(posedge clk) disable iff (!arst_n)
		warm && done |->
			result.new_red >= $past(item.old_red, LAT) &&
			result.new_green >= $past(item.old_green, LAT) &&
			result.new_blue >= $past(item.old_blue, LAT))
		else $error("additive blend darkened a channel");

endmodule

bind ring_halo_pixel_shader_top rhps_checker #(
	.COORD_INT_BITS  (COORD_INT_BITS),
	.COORD_FRAC_BITS (COORD_FRAC_BITS)
) u_rhps_checker (.*);
